// ===== hw/rtl/exact_cover_search_top_defines.svh =====
// Assertion macros for the exact-cover search block.
// Used by the port checker; expects clk and arst_n in the including scope.
`ifndef EXACT_COVER_SEARCH_TOP_DEFINES_SVH
`define EXACT_COVER_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ECS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ECS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ecs_pkg.sv =====
// Shared types and constants of the exact-cover search block.
// No dependencies; the RTL modules and the checker take names from here by scope.
package ecs_pkg;

	localparam int MAX_ROWS_DEF = 8;
	localparam int MAX_COLS_DEF = 8;

	localparam int CFG_W      = 4;
	localparam int ROW_IDX_W  = 3;
	localparam int ROW_BITS_W = 8;
	localparam int SET_W      = 8;
	localparam int TOTAL_W    = 6;

	localparam logic [TOTAL_W-1:0] SOL_CAP   = 6'd63;
	localparam logic [CFG_W-1:0]   ROWS_RST  = 4'd6;
	localparam logic [CFG_W-1:0]   COLS_RST  = 4'd7;

	typedef enum logic {
		CFG_ROWS_IN_USE = 1'b0,
		CFG_COLS_IN_USE = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_START = 1'b1
	} func_t;

	typedef enum logic {
		KIND_SOLUTION = 1'b0,
		KIND_DONE     = 1'b1
	} kind_t;

	typedef struct packed {
		func_t                 func;
		logic [ROW_IDX_W-1:0]  row_index;
		logic [ROW_BITS_W-1:0] row_bits;
	} ecs_in_t;

	typedef struct packed {
		kind_t              kind;
		logic [SET_W-1:0]   row_set;
		logic [TOTAL_W-1:0] solution_total;
		logic               truncated;
		logic               last;
	} ecs_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_TRY,
		ST_POP,
		ST_EMIT_SOL,
		ST_EMIT_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic scan_init;
		logic scan_step;
		logic push;
		logic pop;
		logic emit_sol;
		logic emit_done;
		logic set_trunc;
	} dp_cmd_t;

	typedef struct packed {
		logic all_covered;
		logic count_full;
		logic scan_last;
		logic row_found;
		logic level_zero;
		logic out_free;
	} dp_status_t;

endpackage

// ===== hw/rtl/ecs_stream_if.sv =====
// Valid/ready channel carrying one payload item per handshake.
// Payload type is a parameter; used with ecs_pkg item types.
interface ecs_stream_if #(
	parameter type data_t = logic
) ();
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ecs_dp.sv =====
// Datapath of the exact-cover search: row store, search stacks, column scan,
// row finder and output register. Driven by ecs_ctrl commands; uses ecs_pkg.
module ecs_dp #(
	parameter int MAX_ROWS = ecs_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = ecs_pkg::MAX_COLS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [ecs_pkg::CFG_W-1:0]    cfg_data,
	input  ecs_pkg::ecs_in_t             item,
	input  ecs_pkg::dp_cmd_t             cmd,
	output ecs_pkg::dp_status_t          st,
	input  logic                         out_ready,
	output logic                         out_valid,
	output ecs_pkg::ecs_out_t            out_data
);

	localparam int RowIdxW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int ColIdxW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int LvlW    = $clog2(MAX_COLS + 1);
	localparam int NxtW    = $clog2(MAX_ROWS + 1);
	localparam int SzW     = $clog2(MAX_ROWS + 1);

	logic [ecs_pkg::CFG_W-1:0]   rows_in_use_q;
	logic [ecs_pkg::CFG_W-1:0]   cols_in_use_q;
	logic [MAX_COLS-1:0]         row_store_q [MAX_ROWS];
	logic [RowIdxW-1:0]          row_stack_q [MAX_COLS];
	logic [ColIdxW-1:0]          col_stack_q [MAX_COLS];
	logic [MAX_COLS-1:0]         covered_q;
	logic [LvlW-1:0]             level_q;
	logic [MAX_ROWS-1:0]         set_q;
	logic [ecs_pkg::TOTAL_W-1:0] count_q;
	logic                        trunc_q;
	logic [NxtW-1:0]             next_q;
	logic [ColIdxW-1:0]          scan_j_q;
	logic [ColIdxW-1:0]          best_q;
	logic [SzW-1:0]              best_size_q;
	logic                        best_valid_q;
	logic                        out_valid_q;
	ecs_pkg::ecs_out_t           out_q;

	logic [MAX_COLS-1:0] full_mask;
	logic [MAX_COLS-1:0] rows_m [MAX_ROWS];
	logic [MAX_ROWS-1:0] avail;
	logic [MAX_ROWS-1:0] colv;
	logic [MAX_ROWS-1:0] cand;
	logic [SzW-1:0]      scan_size;
	logic                col_ok;
	logic                take;
	logic [ColIdxW-1:0]  best_next;
	logic [ColIdxW-1:0]  lvl_idx;
	logic [ColIdxW-1:0]  lvl_m1_idx;
	logic [LvlW-1:0]     lvl_m1;
	logic [ColIdxW-1:0]  try_col;
	logic                found;
	logic [RowIdxW-1:0]  found_idx;
	logic [RowIdxW-1:0]  pop_idx;
	logic                load_ok;

	// Active columns and active, masked rows.
	always_comb begin
		for (int j = 0; j < MAX_COLS; j++) begin
			full_mask[j] = (ecs_pkg::CFG_W'(j) < cols_in_use_q);
		end
		for (int i = 0; i < MAX_ROWS; i++) begin
			rows_m[i] = (ecs_pkg::CFG_W'(i) < rows_in_use_q) ?
				(row_store_q[i] & full_mask) : '0;
			avail[i]  = ((rows_m[i] & covered_q) == '0);
		end
	end

	assign lvl_m1     = level_q - LvlW'(1);
	assign lvl_idx    = ColIdxW'(level_q);
	assign lvl_m1_idx = ColIdxW'(lvl_m1);
	assign try_col    = col_stack_q[lvl_idx];
	assign pop_idx    = row_stack_q[lvl_m1_idx];

	// Column scan: candidate count of one column per cycle.
	always_comb begin
		scan_size = '0;
		for (int i = 0; i < MAX_ROWS; i++) begin
			colv[i]   = avail[i] & rows_m[i][scan_j_q];
			scan_size = scan_size + SzW'(colv[i]);
		end
	end

	assign col_ok    = full_mask[scan_j_q] & ~covered_q[scan_j_q];
	assign take      = col_ok & (~best_valid_q | (scan_size < best_size_q));
	assign best_next = take ? scan_j_q : best_q;

	// Lowest candidate row at or above the resume point.
	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		for (int i = 0; i < MAX_ROWS; i++) begin
			cand[i] = avail[i] & rows_m[i][try_col] & (NxtW'(i) >= next_q);
		end
		for (int i = MAX_ROWS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				found     = 1'b1;
				found_idx = RowIdxW'(i);
			end
		end
	end

	assign load_ok = (int'(item.row_index) < MAX_ROWS);

	assign st.all_covered = (covered_q == full_mask);
	assign st.count_full  = (count_q == ecs_pkg::SOL_CAP);
	assign st.scan_last   = (scan_j_q == ColIdxW'(MAX_COLS - 1));
	assign st.row_found   = found;
	assign st.level_zero  = (level_q == '0);
	assign st.out_free    = ~out_valid_q | out_ready;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_in_use_q <= ecs_pkg::ROWS_RST;
			cols_in_use_q <= ecs_pkg::COLS_RST;
			covered_q     <= '0;
			level_q       <= '0;
			set_q         <= '0;
			count_q       <= '0;
			trunc_q       <= 1'b0;
			next_q        <= '0;
			scan_j_q      <= '0;
			best_q        <= '0;
			best_size_q   <= '0;
			best_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ecs_pkg::CFG_ROWS_IN_USE: rows_in_use_q <= cfg_data;
					ecs_pkg::CFG_COLS_IN_USE: cols_in_use_q <= cfg_data;
				endcase
			end
			// Load a new item or drop the one just taken.
			if (cmd.emit_sol || cmd.emit_done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.start) begin
				covered_q <= '0;
				level_q   <= '0;
				set_q     <= '0;
				count_q   <= '0;
				trunc_q   <= 1'b0;
			end
			if (cmd.set_trunc) begin
				trunc_q <= 1'b1;
			end
			if (cmd.scan_init) begin
				scan_j_q     <= '0;
				best_valid_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				best_q       <= best_next;
				best_valid_q <= best_valid_q | take;
				if (take) begin
					best_size_q <= scan_size;
				end
				if (st.scan_last) begin
					next_q <= '0;
				end else begin
					scan_j_q <= scan_j_q + ColIdxW'(1);
				end
			end
			if (cmd.push) begin
				covered_q          <= covered_q | rows_m[found_idx];
				set_q[found_idx]   <= 1'b1;
				level_q            <= level_q + LvlW'(1);
			end
			if (cmd.pop) begin
				covered_q        <= covered_q & ~rows_m[pop_idx];
				set_q[pop_idx]   <= 1'b0;
				level_q          <= lvl_m1;
				next_q           <= NxtW'(pop_idx) + NxtW'(1);
			end
			if (cmd.emit_sol) begin
				count_q <= count_q + ecs_pkg::TOTAL_W'(1);
			end
			if (cmd.emit_done) begin
				covered_q <= '0;
				level_q   <= '0;
			end
		end
	end

	// Payload storage: rows, stacks, output item.
	always_ff @(posedge clk) begin
		if (cmd.load && load_ok) begin
			row_store_q[RowIdxW'(item.row_index)] <= MAX_COLS'(item.row_bits);
		end
		if (cmd.scan_step && st.scan_last) begin
			col_stack_q[lvl_idx] <= best_next;
		end
		if (cmd.push) begin
			row_stack_q[lvl_idx] <= found_idx;
		end
		if (cmd.emit_sol) begin
			out_q.kind           <= ecs_pkg::KIND_SOLUTION;
			out_q.row_set        <= ecs_pkg::SET_W'(set_q);
			out_q.solution_total <= count_q + ecs_pkg::TOTAL_W'(1);
			out_q.truncated      <= 1'b0;
			out_q.last           <= 1'b0;
		end
		if (cmd.emit_done) begin
			out_q.kind           <= ecs_pkg::KIND_DONE;
			out_q.row_set        <= '0;
			out_q.solution_total <= count_q;
			out_q.truncated      <= trunc_q;
			out_q.last           <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hw/rtl/ecs_ctrl.sv =====
// Controller of the exact-cover search: sequences load, descend, scan,
// try, backtrack and emit steps. Uses ecs_pkg state, command and status types.
module ecs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  ecs_pkg::func_t      item_func,
	output logic                item_ready,
	input  ecs_pkg::dp_status_t st,
	output ecs_pkg::dp_cmd_t    cmd
);

	ecs_pkg::state_t state_q;
	ecs_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ecs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ecs_pkg::ST_IDLE: begin
				if (item_valid && item_func == ecs_pkg::FUNC_START) begin
					state_d = ecs_pkg::ST_CHECK;
				end
			end
			ecs_pkg::ST_CHECK: begin
				priority if (!st.all_covered) begin
					state_d = ecs_pkg::ST_SCAN;
				end else if (st.count_full) begin
					state_d = ecs_pkg::ST_EMIT_DONE;
				end else begin
					state_d = ecs_pkg::ST_EMIT_SOL;
				end
			end
			ecs_pkg::ST_SCAN: begin
				if (st.scan_last) begin
					state_d = ecs_pkg::ST_TRY;
				end
			end
			ecs_pkg::ST_TRY: begin
				state_d = st.row_found ? ecs_pkg::ST_CHECK : ecs_pkg::ST_POP;
			end
			ecs_pkg::ST_POP: begin
				state_d = st.level_zero ? ecs_pkg::ST_EMIT_DONE : ecs_pkg::ST_TRY;
			end
			ecs_pkg::ST_EMIT_SOL: begin
				if (st.out_free) begin
					state_d = ecs_pkg::ST_POP;
				end
			end
			ecs_pkg::ST_EMIT_DONE: begin
				if (st.out_free) begin
					state_d = ecs_pkg::ST_IDLE;
				end
			end
			default: state_d = ecs_pkg::ST_IDLE;
		endcase
	end

	// Commands.
	always_comb begin
		cmd        = '0;
		item_ready = (state_q == ecs_pkg::ST_IDLE);
		unique case (state_q)
			ecs_pkg::ST_IDLE: begin
				if (item_valid) begin
					cmd.load  = (item_func == ecs_pkg::FUNC_LOAD);
					cmd.start = (item_func == ecs_pkg::FUNC_START);
				end
			end
			ecs_pkg::ST_CHECK: begin
				cmd.scan_init = ~st.all_covered;
				cmd.set_trunc = st.all_covered & st.count_full;
			end
			ecs_pkg::ST_SCAN:      cmd.scan_step = 1'b1;
			ecs_pkg::ST_TRY:       cmd.push      = st.row_found;
			ecs_pkg::ST_POP:       cmd.pop       = ~st.level_zero;
			ecs_pkg::ST_EMIT_SOL:  cmd.emit_sol  = st.out_free;
			ecs_pkg::ST_EMIT_DONE: cmd.emit_done = st.out_free;
			default:               cmd           = '0;
		endcase
	end

endmodule

// ===== hw/rtl/exact_cover_search_top.sv =====
// Top level of the exact-cover search block (Algorithm X over row bitmasks).
// Instantiates ecs_ctrl and ecs_dp; uses ecs_pkg and ecs_stream_if.
//
//  channel    | dir | handshake          | payload
//  -----------+-----+--------------------+-----------------------------------------
//  item_ch    | in  | valid/ready        | func, row_index, row_bits
//  result_ch  | out | valid/ready        | kind, row_set, solution_total, truncated, last
//  cfg        | in  | cfg_we (no stall)  | cfg_index, cfg_data
//
// A load item returns nothing; item_ch is ready every cycle while idle.
// A start item holds item_ch not ready until its done item is loaded into the output register.
// An open search node runs a check, a scan of all MAX_COLS columns and a try; a full cover runs
// a check and an emit; a backtrack step runs a pop and a try. The scan sets the run time.
// Reset clears control state and restores the configuration (rows_in_use 6, cols_in_use 7).
// A full output register waits for result_ch.ready; the search holds at its next emit until it drains.
module exact_cover_search_top #(
	parameter int MAX_ROWS = ecs_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = ecs_pkg::MAX_COLS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [ecs_pkg::CFG_W-1:0] cfg_data,
	ecs_stream_if.sink                item_ch,
	ecs_stream_if.source              result_ch
);

	ecs_pkg::dp_cmd_t    cmd;
	ecs_pkg::dp_status_t st;
	ecs_pkg::ecs_in_t    item;
	ecs_pkg::ecs_out_t   result;

	// Unpack the incoming item once; both halves read it.
	assign item = item_ch.data;

	// Sequencer: decides what the datapath does each cycle.
	ecs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_ch.valid),
		.item_func  (item.func),
		.item_ready (item_ch.ready),
		.st         (st),
		.cmd        (cmd)
	);

	// Datapath: rows, search stacks, scan and output register.
	ecs_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.st        (st),
		.out_ready (result_ch.ready),
		.out_valid (result_ch.valid),
		.out_data  (result)
	);

	assign result_ch.data = result;

endmodule

// ===== hw/rtl/ecs_checker.sv =====
// Port-level checker for the exact-cover search top level, attached by bind.
// Depends on ecs_pkg and exact_cover_search_top_defines.svh.
`include "exact_cover_search_top_defines.svh"

module ecs_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input ecs_pkg::func_t    item_func,
	input logic              out_valid,
	input logic              out_ready,
	input ecs_pkg::ecs_out_t out_data
);

	// A stalled result item holds.
	`ECS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result item changed while stalled")

	// A start item closes the input until its run ends.
	`ECS_ASSERT_NEXT(a_start_busy, item_valid && item_ready && item_func == ecs_pkg::FUNC_START, !item_ready, "input ready right after a start item")

	// The done item is the last one and carries no row set.
	`ECS_ASSERT_NOW(a_done_shape, out_valid && out_data.kind == ecs_pkg::KIND_DONE, out_data.last && out_data.row_set == '0, "malformed done item")

	// A solution item counts itself and is never last.
	`ECS_ASSERT_NOW(a_sol_shape, out_valid && out_data.kind == ecs_pkg::KIND_SOLUTION, !out_data.last && !out_data.truncated && out_data.solution_total != '0, "malformed solution item")

endmodule

bind exact_cover_search_top ecs_checker u_ecs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_ch.valid),
	.item_ready (item_ch.ready),
	.item_func  (item_ch.data.func),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.out_data   (result_ch.data)
);
